>>> src/tps_eval_pkg.sv
// ----------------------------------------------------------------------------
// tps_eval_pkg
// Shared types, codes and constants for the thin-plate spline evaluator.
// ----------------------------------------------------------------------------
package tps_eval_pkg;

  localparam int NUM_CENTERS_DEF = 64;
  localparam int CFG_IDX_W       = 3;

  // round(ln2 * 2^32)
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FITTED  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AFF_X,
    ST_AFF_X_ADD,
    ST_AFF_Y,
    ST_AFF_Y_ADD,
    ST_RD,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_DSUM,
    ST_NORM,
    ST_SQR,
    ST_LN_MUL,
    ST_LN_RND,
    ST_MD0,
    ST_AD0,
    ST_MD1,
    ST_AD1,
    ST_MW0,
    ST_AW0,
    ST_MW1,
    ST_AW1,
    ST_MW2,
    ST_AW2,
    ST_ACC,
    ST_DONE
  } tps_state_t;

  // magnitude of a signed 32-bit value; the most negative value fits unsigned
  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> src/tps_eval_ram.sv
// ----------------------------------------------------------------------------
// tps_eval_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tps_eval_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/thin_plate_spline_eval.sv
// ----------------------------------------------------------------------------
// thin_plate_spline_eval
// Thin-plate spline evaluator on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// A load item writes one center (x, y, weight) into the center RAM. An
// evaluate item returns b0 + b1*p + b2*q plus weight*d*ln(d)/2 over
// the first center_count centers as saturated signed Q32.32. Every product
// runs through one 32x32 multiplier under a sequencer: per center, 6
// normalize steps, 16 squaring steps for the log fraction and 5 partial
// products for weight*d*ln are taken in turn; a center at distance zero
// skips the log term. With fitted low the sequencer goes straight to its
// done state and the answer is zero. Input is taken only while the
// sequencer is idle; a finished result waits in the output register while
// the next item is accepted.
// ----------------------------------------------------------------------------
module thin_plate_spline_eval #(
  parameter int NUM_CENTERS = tps_eval_pkg::NUM_CENTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tps_eval_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [5:0]                          center_index,
  input  logic signed [31:0]                  coord_x,
  input  logic signed [31:0]                  coord_y,
  input  logic signed [31:0]                  weight,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [63:0]                  value,
  output logic                                saturated
);

  localparam int AW  = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
  localparam int CW  = $clog2(NUM_CENTERS + 1);
  localparam int IXW = 11;

  tps_eval_pkg::tps_state_t state, state_next;

  logic signed [31:0] offset_coef, slope_x_coef, slope_y_coef;
  logic [6:0]         center_count;
  logic               fitted;

  logic signed [31:0] qp, qq;
  logic [CW-1:0]      n_ctr, j;
  logic [31:0]        ax, ay, wmag;
  logic               wneg, lneg;
  logic [63:0]        prod, sx, d, nrm;
  logic [5:0]         lz;
  logic [2:0]         step;
  logic [31:0]        m;
  logic [15:0]        frac;
  logic [3:0]         sq_cnt;
  logic [21:0]        lnmag;
  logic [95:0]        t;
  logic [127:0]       pw;
  logic signed [63:0] acc;
  logic               sat;

  logic               in_acc, out_free;
  logic [IXW-1:0]     idx_ext, cc_ext, n_min;
  logic               wr_en;
  logic [95:0]        rd_data;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [32:0]        dxs, dys;
  logic [64:0]        dsum65;
  logic [63:0]        d_sum;
  logic [63:0]        nrm_next;
  logic [5:0]         lz_next, e;
  logic [21:0]        lmag;
  logic [63:0]        rnd;
  logic               add_neg, add_huge, add_hit;
  logic [63:0]        add_mag, add_res;
  logic [65:0]        a66, s66;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != tps_eval_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // center table: {weight, y, x}
  assign idx_ext = {5'b0, center_index};
  assign wr_en   = in_acc && (command == tps_eval_pkg::CMD_LOAD) &&
                   (idx_ext < IXW'(NUM_CENTERS));
  assign cc_ext  = {4'b0, center_count};
  assign n_min   = (cc_ext > IXW'(NUM_CENTERS)) ? IXW'(NUM_CENTERS) : cc_ext;

  tps_eval_ram #(
    .WIDTH  (96),
    .DEPTH  (NUM_CENTERS),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data ({weight, coord_y, coord_x}),
    .rd_addr (j[AW-1:0]),
    .rd_data (rd_data)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      tps_eval_pkg::ST_AFF_X: begin
        mul_a = tps_eval_pkg::abs32(slope_x_coef);
        mul_b = tps_eval_pkg::abs32(qp);
      end
      tps_eval_pkg::ST_AFF_Y: begin
        mul_a = tps_eval_pkg::abs32(slope_y_coef);
        mul_b = tps_eval_pkg::abs32(qq);
      end
      tps_eval_pkg::ST_SQ_X: begin
        mul_a = ax;
        mul_b = ax;
      end
      tps_eval_pkg::ST_SQ_Y: begin
        mul_a = ay;
        mul_b = ay;
      end
      tps_eval_pkg::ST_SQR: begin
        mul_a = m;
        mul_b = m;
      end
      tps_eval_pkg::ST_LN_MUL: begin
        mul_a = {10'b0, lmag};
        mul_b = tps_eval_pkg::LN2_Q32;
      end
      tps_eval_pkg::ST_MD0: begin
        mul_a = d[31:0];
        mul_b = {10'b0, lnmag};
      end
      tps_eval_pkg::ST_MD1: begin
        mul_a = d[63:32];
        mul_b = {10'b0, lnmag};
      end
      tps_eval_pkg::ST_MW0: begin
        mul_a = t[31:0];
        mul_b = wmag;
      end
      tps_eval_pkg::ST_MW1: begin
        mul_a = t[63:32];
        mul_b = wmag;
      end
      tps_eval_pkg::ST_MW2: begin
        mul_a = t[95:64];
        mul_b = wmag;
      end
      default: ;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // differences and squared distance
  assign dxs    = {qp[31], qp} - {rd_data[31], rd_data[31:0]};
  assign dys    = {qq[31], qq} - {rd_data[63], rd_data[63:32]};
  assign dsum65 = {1'b0, sx} + {1'b0, prod};
  assign d_sum  = dsum65[64] ? {64{1'b1}} : dsum65[63:0];

  // one step of the leading-zero search
  always_comb begin
    nrm_next = nrm;
    lz_next  = lz;
    unique case (step)
      3'd0: if (nrm[63:32] == '0) begin
        nrm_next = {nrm[31:0], 32'b0};
        lz_next  = lz + 6'd32;
      end
      3'd1: if (nrm[63:48] == '0) begin
        nrm_next = {nrm[47:0], 16'b0};
        lz_next  = lz + 6'd16;
      end
      3'd2: if (nrm[63:56] == '0) begin
        nrm_next = {nrm[55:0], 8'b0};
        lz_next  = lz + 6'd8;
      end
      3'd3: if (nrm[63:60] == '0) begin
        nrm_next = {nrm[59:0], 4'b0};
        lz_next  = lz + 6'd4;
      end
      3'd4: if (nrm[63:62] == '0) begin
        nrm_next = {nrm[61:0], 2'b0};
        lz_next  = lz + 6'd2;
      end
      3'd5: if (!nrm[63]) begin
        nrm_next = {nrm[62:0], 1'b0};
        lz_next  = lz + 6'd1;
      end
      default: ;
    endcase
  end

  // |log2| in Q.16 from exponent and fraction
  assign e    = 6'd63 - lz;
  assign lmag = e[5] ? {1'b0, e[4:0], frac}
                     : ({(6'd32 - e), 16'b0} - {6'b0, frac});
  assign rnd  = prod + 64'h0000_0000_8000_0000;

  // saturating accumulator add
  always_comb begin
    add_neg  = 1'b0;
    add_mag  = '0;
    add_huge = 1'b0;
    unique case (state)
      tps_eval_pkg::ST_AFF_X_ADD: begin
        add_neg = slope_x_coef[31] ^ qp[31];
        add_mag = prod;
      end
      tps_eval_pkg::ST_AFF_Y_ADD: begin
        add_neg = slope_y_coef[31] ^ qq[31];
        add_mag = prod;
      end
      tps_eval_pkg::ST_ACC: begin
        add_neg  = wneg ^ lneg;
        add_mag  = pw[96:33];
        add_huge = (pw[127:97] != '0);
      end
      default: ;
    endcase
    a66 = {{2{acc[63]}}, acc};
    s66 = add_neg ? (a66 - {2'b0, add_mag}) : (a66 + {2'b0, add_mag});
    add_hit = 1'b0;
    add_res = s66[63:0];
    if (add_huge) begin
      add_hit = 1'b1;
      add_res = add_neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else if (!s66[65] && (s66[64:63] != 2'b00)) begin
      add_hit = 1'b1;
      add_res = {1'b0, {63{1'b1}}};
    end else if (s66[65] && (s66[64:63] != 2'b11)) begin
      add_hit = 1'b1;
      add_res = {1'b1, 63'b0};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tps_eval_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tps_eval_pkg::ST_IDLE:
        if (in_acc && (command == tps_eval_pkg::CMD_EVAL)) begin
          state_next = fitted ? tps_eval_pkg::ST_AFF_X : tps_eval_pkg::ST_DONE;
        end
      tps_eval_pkg::ST_AFF_X:     state_next = tps_eval_pkg::ST_AFF_X_ADD;
      tps_eval_pkg::ST_AFF_X_ADD: state_next = tps_eval_pkg::ST_AFF_Y;
      tps_eval_pkg::ST_AFF_Y:     state_next = tps_eval_pkg::ST_AFF_Y_ADD;
      tps_eval_pkg::ST_AFF_Y_ADD: state_next = tps_eval_pkg::ST_RD;
      tps_eval_pkg::ST_RD:
        state_next = (j == n_ctr) ? tps_eval_pkg::ST_DONE : tps_eval_pkg::ST_DIFF;
      tps_eval_pkg::ST_DIFF:      state_next = tps_eval_pkg::ST_SQ_X;
      tps_eval_pkg::ST_SQ_X:      state_next = tps_eval_pkg::ST_SQ_Y;
      tps_eval_pkg::ST_SQ_Y:      state_next = tps_eval_pkg::ST_DSUM;
      tps_eval_pkg::ST_DSUM:
        state_next = (d_sum == '0) ? tps_eval_pkg::ST_RD : tps_eval_pkg::ST_NORM;
      tps_eval_pkg::ST_NORM:
        if (step == 3'd5) begin
          state_next = tps_eval_pkg::ST_SQR;
        end
      tps_eval_pkg::ST_SQR:
        if (sq_cnt == 4'd15) begin
          state_next = tps_eval_pkg::ST_LN_MUL;
        end
      tps_eval_pkg::ST_LN_MUL:    state_next = tps_eval_pkg::ST_LN_RND;
      tps_eval_pkg::ST_LN_RND:    state_next = tps_eval_pkg::ST_MD0;
      tps_eval_pkg::ST_MD0:       state_next = tps_eval_pkg::ST_AD0;
      tps_eval_pkg::ST_AD0:       state_next = tps_eval_pkg::ST_MD1;
      tps_eval_pkg::ST_MD1:       state_next = tps_eval_pkg::ST_AD1;
      tps_eval_pkg::ST_AD1:       state_next = tps_eval_pkg::ST_MW0;
      tps_eval_pkg::ST_MW0:       state_next = tps_eval_pkg::ST_AW0;
      tps_eval_pkg::ST_AW0:       state_next = tps_eval_pkg::ST_MW1;
      tps_eval_pkg::ST_MW1:       state_next = tps_eval_pkg::ST_AW1;
      tps_eval_pkg::ST_AW1:       state_next = tps_eval_pkg::ST_MW2;
      tps_eval_pkg::ST_MW2:       state_next = tps_eval_pkg::ST_AW2;
      tps_eval_pkg::ST_AW2:       state_next = tps_eval_pkg::ST_ACC;
      tps_eval_pkg::ST_ACC:       state_next = tps_eval_pkg::ST_RD;
      tps_eval_pkg::ST_DONE:
        if (out_free) begin
          state_next = tps_eval_pkg::ST_IDLE;
        end
      default:                    state_next = tps_eval_pkg::ST_IDLE;
    endcase
  end

  // configuration registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_coef  <= '0;
      slope_x_coef <= '0;
      slope_y_coef <= '0;
      center_count <= '0;
      fitted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tps_eval_pkg::CFG_OFFSET:  offset_coef  <= cfg_data;
          tps_eval_pkg::CFG_SLOPE_X: slope_x_coef <= cfg_data;
          tps_eval_pkg::CFG_SLOPE_Y: slope_y_coef <= cfg_data;
          tps_eval_pkg::CFG_COUNT:   center_count <= cfg_data[6:0];
          tps_eval_pkg::CFG_FITTED:  fitted       <= cfg_data[0];
          default: ;
        endcase
      end
      if ((state == tps_eval_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tps_eval_pkg::ST_DONE) && out_free) begin
      value     <= acc;
      saturated <= sat;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      j     <= '0;
      n_ctr <= '0;
    end else begin
      unique case (state)
        tps_eval_pkg::ST_IDLE:
          if (in_acc && (command == tps_eval_pkg::CMD_EVAL)) begin
            qp    <= coord_x;
            qq    <= coord_y;
            acc   <= fitted ? {{16{offset_coef[31]}}, offset_coef, 16'b0} : '0;
            sat   <= 1'b0;
            j     <= '0;
            n_ctr <= n_min[CW-1:0];
          end
        tps_eval_pkg::ST_AFF_X, tps_eval_pkg::ST_AFF_Y, tps_eval_pkg::ST_SQ_Y,
        tps_eval_pkg::ST_LN_MUL, tps_eval_pkg::ST_MD0, tps_eval_pkg::ST_MD1,
        tps_eval_pkg::ST_MW0, tps_eval_pkg::ST_MW1, tps_eval_pkg::ST_MW2:
          prod <= mul_p;
        tps_eval_pkg::ST_AFF_X_ADD, tps_eval_pkg::ST_AFF_Y_ADD: begin
          acc <= add_res;
          sat <= sat | add_hit;
        end
        tps_eval_pkg::ST_DIFF: begin
          ax   <= dxs[32] ? 32'(~dxs + 33'd1) : dxs[31:0];
          ay   <= dys[32] ? 32'(~dys + 33'd1) : dys[31:0];
          wmag <= tps_eval_pkg::abs32(rd_data[95:64]);
          wneg <= rd_data[95];
        end
        tps_eval_pkg::ST_SQ_X: sx <= mul_p;
        tps_eval_pkg::ST_DSUM: begin
          d    <= d_sum;
          nrm  <= d_sum;
          lz   <= '0;
          step <= '0;
          if (d_sum == '0) begin
            j <= j + CW'(1);
          end
        end
        tps_eval_pkg::ST_NORM: begin
          nrm    <= nrm_next;
          lz     <= lz_next;
          step   <= step + 3'd1;
          m      <= nrm_next[63:32];
          frac   <= '0;
          sq_cnt <= '0;
        end
        tps_eval_pkg::ST_SQR: begin
          // square, keep the mantissa in [1,2) and shift out one fraction bit
          m      <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
          frac   <= {frac[14:0], mul_p[63]};
          sq_cnt <= sq_cnt + 4'd1;
        end
        tps_eval_pkg::ST_LN_RND: begin
          lnmag <= rnd[53:32];
          lneg  <= ~e[5];
        end
        tps_eval_pkg::ST_AD0: t  <= {32'b0, prod};
        tps_eval_pkg::ST_AD1: t  <= t + {prod, 32'b0};
        tps_eval_pkg::ST_AW0: pw <= {64'b0, prod};
        tps_eval_pkg::ST_AW1: pw <= pw + {32'b0, prod, 32'b0};
        tps_eval_pkg::ST_AW2: pw <= pw + {prod, 64'b0};
        tps_eval_pkg::ST_ACC: begin
          acc <= add_res;
          sat <= sat | add_hit;
          j   <= j + CW'(1);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (command == tps_eval_pkg::CMD_EVAL)) |=> (state != tps_eval_pkg::ST_IDLE))
    else $error("evaluate item did not start the sequencer");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (command == tps_eval_pkg::CMD_LOAD)) |=> (state == tps_eval_pkg::ST_IDLE))
    else $error("load item left the sequencer busy");

  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    (state == tps_eval_pkg::ST_SQR) |-> m[31])
    else $error("log mantissa not normalized");

  a_ctr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tps_eval_pkg::ST_RD) |-> (j <= n_ctr))
    else $error("center counter ran past the count");
`endif

endmodule
